>>> rtl/sll_pkg.sv
// shared types and constants for the sorted linked list engine
// no dependencies; imported by every other file in rtl
package sll_pkg;

    localparam int KEY_BITS  = 20;
    localparam int COUNT_W   = 5;
    localparam int NODES_DEF = 16;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    typedef struct packed {
        t_op                 op;
        logic [KEY_BITS-1:0] key;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [COUNT_W-1:0]  count;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_CHECK,
        S_LINK1,
        S_LINK2,
        S_RESULT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    load_req;
        logic    rd_cur;
        logic    step;
        logic    hit;
        logic    link1;
        logic    link2;
        logic    load_out;
        t_status status;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_remove;
        logic full;
        logic cur_null;
        logic less;
        logic next_null;
        logic hit_eq;
        logic out_busy;
    } t_dp_stat;

endpackage

>>> rtl/sorted_linked_list_engine.sv
// sorted linked list engine: one request at a time; the walk visits the held nodes one per
// cycle via the registered read port; a full insert skips the walk and the relinking, and a
// remove with no match skips the relinking; a result waits while the one before is still
// held, and the next request is taken the cycle after the result is registered. synchronous
// active-low reset empties the list at once, no clearing pass: unused nodes are handed out in
// order from a fill counter
module sorted_linked_list_engine #(
    parameter int NODES = sll_pkg::NODES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sll_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sll_pkg::t_rsp o_out_data
);
    import sll_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    sll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    sll_dp #(
        .NODES (NODES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/sll_ctrl.sv
// sequencing state machine for the list walk and relinking
// depends on sll_pkg
module sll_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  sll_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output sll_pkg::t_dp_cmd  o_cmd
);
    import sll_pkg::*;

    t_state  r_state, n_state;
    t_status r_result, n_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_result <= ST_DONE;
        end else begin
            r_state  <= n_state;
            r_result <= n_result;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_result   = r_result;
        o_cmd      = '0;
        o_cmd.status = r_result;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_START;
                end
            end
            S_START: begin
                if (!i_stat.is_remove && i_stat.full) begin
                    n_result = ST_FULL;
                    n_state  = S_RESULT;
                end else if (i_stat.cur_null) begin
                    n_state = S_CHECK;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_state      = S_WALK;
                end
            end
            S_WALK: begin
                // one node compared per cycle, next read issued from the link just read
                if (i_stat.less) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.next_null) begin
                        n_state = S_CHECK;
                    end
                end else begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.is_remove && (i_stat.cur_null || !i_stat.hit_eq)) begin
                    n_result = ST_MISSING;
                    n_state  = S_RESULT;
                end else begin
                    n_state = S_LINK1;
                end
            end
            S_LINK1: begin
                o_cmd.link1 = 1'b1;
                n_state     = S_LINK2;
            end
            S_LINK2: begin
                o_cmd.link2 = 1'b1;
                n_result    = ST_DONE;
                n_state     = S_RESULT;
            end
            S_RESULT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/sll_dp.sv
// node pool, link memory, list and free list pointers, output register
// depends on sll_pkg
module sll_dp #(
    parameter int NODES = sll_pkg::NODES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  sll_pkg::t_req     i_in_data,
    input  logic              i_out_ready,
    input  sll_pkg::t_dp_cmd  i_cmd,
    output sll_pkg::t_dp_stat o_stat,
    output logic              o_out_valid,
    output sll_pkg::t_rsp     o_out_data
);
    import sll_pkg::*;

    localparam int LINK_W = $clog2(NODES + 1);
    localparam int IDX_W  = $clog2(NODES);
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NODES);

    logic [KEY_BITS-1:0] key_mem  [NODES];
    logic [LINK_W-1:0]   link_mem [NODES];

    logic [KEY_BITS-1:0] r_key;
    t_op                 r_op;
    logic [LINK_W-1:0]   r_cur, r_prev, r_node, r_at_next;
    logic                r_eq;
    logic [LINK_W-1:0]   r_list_head, r_rec_head, r_fill, r_count;
    logic [KEY_BITS-1:0] r_rd_key;
    logic [LINK_W-1:0]   r_rd_next, r_free_next;
    logic                r_out_valid;
    t_rsp                r_out;

    logic [LINK_W-1:0]   rd_addr, alloc, link_wa, link_wd;
    logic                rd_en, link_we, key_we, is_ins, prev_null, next_null;

    assign is_ins    = (r_op == OP_INSERT);
    assign prev_null = (r_prev == LINK_NULL);
    assign next_null = (r_rd_next == LINK_NULL);
    // recycled nodes first, then nodes never handed out
    assign alloc     = (r_rec_head == LINK_NULL) ? r_fill : r_rec_head;
    assign rd_addr   = i_cmd.step ? r_rd_next : r_cur;
    assign rd_en     = i_cmd.rd_cur | (i_cmd.step & !next_null);
    assign key_we    = i_cmd.link1 & is_ins;

    always_comb begin
        link_we = 1'b0;
        link_wa = r_cur;
        link_wd = r_rec_head;
        if (i_cmd.link1) begin
            link_we = 1'b1;
            if (is_ins) begin
                link_wa = alloc;
                link_wd = r_cur;
            end
        end else if (i_cmd.link2 && !prev_null) begin
            link_we = 1'b1;
            link_wa = r_prev;
            link_wd = is_ins ? r_node : r_at_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_wa[IDX_W-1:0]] <= link_wd;
        end
        if (key_we) begin
            key_mem[alloc[IDX_W-1:0]] <= r_key;
        end
        if (rd_en) begin
            r_rd_key  <= key_mem[rd_addr[IDX_W-1:0]];
            r_rd_next <= link_mem[rd_addr[IDX_W-1:0]];
        end
        // second read port follows the head of the recycled chain
        r_free_next <= link_mem[r_rec_head[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req && i_in_valid) begin
            r_op   <= i_in_data.op;
            r_key  <= i_in_data.key;
            r_cur  <= r_list_head;
            r_prev <= LINK_NULL;
        end
        if (i_cmd.step) begin
            r_prev <= r_cur;
            r_cur  <= r_rd_next;
        end
        if (i_cmd.hit) begin
            r_eq      <= (r_rd_key == r_key);
            r_at_next <= r_rd_next;
        end
        if (i_cmd.link1) begin
            r_node <= alloc;
        end
        if (i_cmd.load_out) begin
            r_out.status <= i_cmd.status;
            r_out.count  <= COUNT_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_head <= LINK_NULL;
            r_rec_head  <= LINK_NULL;
            r_fill      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.link1) begin
                if (is_ins) begin
                    if (r_rec_head == LINK_NULL) begin
                        r_fill <= r_fill + 1'b1;
                    end else begin
                        r_rec_head <= r_free_next;
                    end
                    r_count <= r_count + 1'b1;
                end else begin
                    r_rec_head <= r_cur;
                    r_count    <= r_count - 1'b1;
                end
            end
            if (i_cmd.link2 && prev_null) begin
                r_list_head <= is_ins ? r_node : r_at_next;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.is_remove = (r_op == OP_REMOVE);
    assign o_stat.full      = (r_count == LINK_NULL);
    assign o_stat.cur_null  = (r_cur == LINK_NULL);
    assign o_stat.less      = (r_rd_key < r_key);
    assign o_stat.next_null = next_null;
    assign o_stat.hit_eq    = r_eq;
    assign o_stat.out_busy  = r_out_valid & !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> tb/sv/sorted_linked_list_engine_test.sv
// self-checking testbench for the sorted linked list engine: directed table, then random
// insert/remove traffic scored against an in-bench model of the sorted node pool
// depends on rtl/sll_pkg.sv and rtl/sorted_linked_list_engine.sv
`timescale 1ns / 1ps

module sorted_linked_list_engine_test;
    import sll_pkg::*;

    localparam int NODE_CNT     = NODES_DEF;
    localparam int RANDOM_ITEMS = 1825;
    localparam int MAX_REPORTS  = 10;
    localparam logic [4:0] LINK_NONE = 5'(NODE_CNT);
    localparam logic [KEY_BITS-1:0] KEY_MAX = '1;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_plan_entry;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b1;
    t_req i_in_data   = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_rsp o_out_data;

    // shadow of the node pool
    logic [KEY_BITS-1:0] pool_key [NODE_CNT];
    logic [4:0]          pool_next [NODE_CNT];
    logic [4:0]          chain_head;
    logic [4:0]          free_head;
    logic [4:0]          held_keys;

    t_rsp        pending_rsp [$];
    t_plan_entry directed_plan [$];
    int          fault_count = 0;
    bit          calm = 1'b0;

    sorted_linked_list_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void pool_clear();
        for (int n = 0; n < NODE_CNT; n++) begin
            pool_key[n]  = '0;
            pool_next[n] = 5'(n + 1);
        end
        pool_next[NODE_CNT-1] = LINK_NONE;
        chain_head = LINK_NONE;
        free_head  = 5'd0;
        held_keys  = 5'd0;
    endfunction

    function automatic t_rsp apply_request(t_req r);
        logic [4:0] prev;
        logic [4:0] cur;
        logic [4:0] node;
        int         steps;
        t_rsp       rsp;
        prev  = LINK_NONE;
        cur   = chain_head;
        steps = 0;
        // first node whose key is not below the request key
        while (cur < NODE_CNT && steps < NODE_CNT && pool_key[cur] < r.key) begin
            prev = cur;
            cur  = pool_next[cur];
            steps++;
        end
        if (r.op == OP_INSERT) begin
            if (free_head >= NODE_CNT) begin
                rsp.status = ST_FULL;
            end else begin
                node             = free_head;
                free_head        = pool_next[node];
                pool_key[node]   = r.key;
                if (prev < NODE_CNT) begin
                    pool_next[node] = pool_next[prev];
                    pool_next[prev] = node;
                end else begin
                    pool_next[node] = chain_head;
                    chain_head      = node;
                end
                held_keys  = held_keys + 5'd1;
                rsp.status = ST_DONE;
            end
        end else if (cur >= NODE_CNT || pool_key[cur] != r.key) begin
            rsp.status = ST_MISSING;
        end else begin
            if (prev < NODE_CNT) begin
                pool_next[prev] = pool_next[cur];
            end else begin
                chain_head = pool_next[cur];
            end
            pool_next[cur] = free_head;
            free_head      = cur;
            if (held_keys > 0) held_keys = held_keys - 5'd1;
            rsp.status = ST_DONE;
        end
        rsp.count = held_keys;
        return rsp;
    endfunction

    function automatic logic [KEY_BITS-1:0] held_key(int pos);
        logic [4:0] cur;
        cur = chain_head;
        repeat (pos) cur = pool_next[cur];
        return pool_key[cur];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key(t_op op);
        logic [KEY_BITS-1:0] key_pool [12];
        int                  r;
        key_pool = '{20'h00000, 20'hFFFFF, 20'h00001, 20'hFFFFE, 20'h80000, 20'h7FFFF,
                     20'h55555, 20'hAAAAA, 20'h00400, 20'h00401, 20'h12345, 20'hFEDCB};
        r = $urandom_range(99);
        if (r < 40) return key_pool[$urandom_range(11)];
        if (r < 65 && held_keys > 0 && op == OP_REMOVE)
            return held_key($urandom_range(held_keys - 1));
        // neighbours of held keys probe the compare boundary
        if (r < 75 && held_keys > 0)
            return KEY_BITS'(held_key($urandom_range(held_keys - 1))
                             + ($urandom_range(1) ? 1 : -1));
        return KEY_BITS'($urandom);
    endfunction

    function automatic t_plan_entry plan_entry(t_op op, logic [KEY_BITS-1:0] key, bit typed,
                                               t_status st, logic [COUNT_W-1:0] cnt);
        t_plan_entry e;
        e.req.op     = op;
        e.req.key    = key;
        e.typed      = typed;
        e.rsp.status = st;
        e.rsp.count  = cnt;
        return e;
    endfunction

    task automatic report_fault(input string msg);
        if (fault_count < MAX_REPORTS) $display("mismatch: %s", msg);
        fault_count++;
    endtask

    // drives one request, queues its expected result on acceptance, then idles the sender for a random gap unless calm
    task automatic send_request(input t_req r, input bit typed, input t_rsp typed_rsp);
        t_rsp predicted;
        int   gap;
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = apply_request(r);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_requests();
        i_in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rsp.size() == 0) begin
                report_fault($sformatf("unexpected result status %0d count %0d",
                                       o_out_data.status, o_out_data.count));
            end else begin
                want = pending_rsp.pop_front();
                if (o_out_data.status !== want.status)
                    report_fault($sformatf("status expected %0d got %0d",
                                           want.status, o_out_data.status));
                if (o_out_data.count !== want.count)
                    report_fault($sformatf("count expected %0d got %0d",
                                           want.count, o_out_data.count));
            end
        end
    end

    // receiver back-pressure
    initial begin : rx_stall
        int hold;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(3) == 0) begin
                hold = pick_gap();
                if (hold > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (hold) @(posedge i_clk);
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    initial begin : stimulus
        t_plan_entry e;
        t_req        req;
        t_rsp        none;
        int          ins_pct;
        none    = '0;
        ins_pct = 50;
        pool_clear();

        directed_plan.push_back(plan_entry(OP_REMOVE, 20'h00000, 1, ST_MISSING, 5'd0));
        directed_plan.push_back(plan_entry(OP_INSERT, 20'h00000, 1, ST_DONE, 5'd1));
        directed_plan.push_back(plan_entry(OP_INSERT, KEY_MAX, 1, ST_DONE, 5'd2));
        directed_plan.push_back(plan_entry(OP_INSERT, KEY_MAX, 0, ST_DONE, 5'd0));
        directed_plan.push_back(plan_entry(OP_REMOVE, KEY_MAX, 0, ST_DONE, 5'd0));
        directed_plan.push_back(plan_entry(OP_REMOVE, 20'h00005, 0, ST_DONE, 5'd0));
        // fill the pool, with duplicates and keys on both sides of the held ones
        directed_plan.push_back(plan_entry(OP_INSERT, 20'h55555, 0, ST_DONE, 5'd0));
        directed_plan.push_back(plan_entry(OP_INSERT, 20'hAAAAA, 0, ST_DONE, 5'd0));
        directed_plan.push_back(plan_entry(OP_INSERT, 20'h00001, 0, ST_DONE, 5'd0));
        directed_plan.push_back(plan_entry(OP_INSERT, 20'h80000, 0, ST_DONE, 5'd0));
        directed_plan.push_back(plan_entry(OP_INSERT, 20'h7FFFF, 0, ST_DONE, 5'd0));
        directed_plan.push_back(plan_entry(OP_INSERT, 20'h12345, 0, ST_DONE, 5'd0));
        directed_plan.push_back(plan_entry(OP_INSERT, 20'h12345, 0, ST_DONE, 5'd0));
        directed_plan.push_back(plan_entry(OP_INSERT, 20'hFEDCB, 0, ST_DONE, 5'd0));
        directed_plan.push_back(plan_entry(OP_INSERT, 20'h00010, 0, ST_DONE, 5'd0));
        directed_plan.push_back(plan_entry(OP_INSERT, 20'h40000, 0, ST_DONE, 5'd0));
        directed_plan.push_back(plan_entry(OP_INSERT, 20'h00003, 0, ST_DONE, 5'd0));
        directed_plan.push_back(plan_entry(OP_INSERT, 20'h00003, 0, ST_DONE, 5'd0));
        directed_plan.push_back(plan_entry(OP_INSERT, 20'hC0000, 0, ST_DONE, 5'd0));
        directed_plan.push_back(plan_entry(OP_INSERT, 20'h00002, 0, ST_DONE, 5'd0));
        directed_plan.push_back(plan_entry(OP_INSERT, KEY_MAX, 1, ST_FULL, 5'd16));
        directed_plan.push_back(plan_entry(OP_REMOVE, 20'h00000, 1, ST_DONE, 5'd15));
        directed_plan.push_back(plan_entry(OP_REMOVE, KEY_MAX, 0, ST_DONE, 5'd0));
        directed_plan.push_back(plan_entry(OP_REMOVE, 20'h00005, 0, ST_DONE, 5'd0));
        directed_plan.push_back(plan_entry(OP_INSERT, 20'h00000, 0, ST_DONE, 5'd0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[i]) begin
            e = directed_plan[i];
            send_request(e.req, e.typed, e.rsp);
        end
        drain_requests();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // every 40 requests pick a growing, balanced or shrinking mix at random, to reach both full and empty
            if (n % 40 == 0) begin
                case ($urandom_range(2))
                    0: begin
                        ins_pct = 80;
                    end
                    1: begin
                        ins_pct = 50;
                    end
                    default: begin
                        ins_pct = 20;
                    end
                endcase
            end
            if (n % 300 == 150) calm = 1'b1;
            if (n % 300 == 210) calm = 1'b0;
            if (n % 250 == 249) drain_requests();
            req.op  = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
            req.key = pick_key(req.op);
            send_request(req, 1'b0, none);
        end

        drain_requests();
        repeat (40) @(posedge i_clk);
        if (fault_count == 0 && pending_rsp.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
rtl/sll_pkg.sv
rtl/sll_ctrl.sv
rtl/sll_dp.sv
rtl/sorted_linked_list_engine.sv
tb/sv/sorted_linked_list_engine_test.sv
